/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the placer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is switched off while reset is held.
`define LLP_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that also holds while reset is held.
`define LLP_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/llp_pkg.sv */
// ----------------------------------------------------------------------------
// llp_pkg
// Field widths, request codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package llp_pkg;

    localparam int unsigned OPCODE_WIDTH   = 2;
    localparam int unsigned KEY_WIDTH      = 64;
    localparam int unsigned URG_WIDTH      = 4;
    localparam int unsigned TGT_WIDTH      = 10;
    localparam int unsigned RANK_OUT_WIDTH = 10;
    localparam int unsigned LOAD_OUT_WIDTH = 16;
    localparam int unsigned CFG_WIDTH      = 11;
    localparam int unsigned MARGIN_CAP     = 3;

    localparam logic [CFG_WIDTH-1:0] ACTIVE_RESET = CFG_WIDTH'(1);

    localparam logic [OPCODE_WIDTH-1:0] OP_CHOOSE = 2'd0;
    localparam logic [OPCODE_WIDTH-1:0] OP_PLACE  = 2'd1;
    localparam logic [OPCODE_WIDTH-1:0] OP_DONE   = 2'd2;
    localparam logic [OPCODE_WIDTH-1:0] OP_READ   = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic clr_step;
        logic dispatch_rd;
        logic scan_init;
        logic scan_step;
        logic home_rd;
        logic tgt_finish;
        logic decide;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic is_choose;
        logic ws_zero;
        logic scan_done;
        logic div_done;
    } t_status;

endpackage

/* rtl/llp_ram.sv */
// ----------------------------------------------------------------------------
// llp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module llp_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/llp_mod.sv */
// ----------------------------------------------------------------------------
// llp_mod
// Bit-serial restoring remainder unit: 64-bit key modulo the rank count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module llp_mod import llp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [KEY_WIDTH-1:0] i_dividend,
    input  logic [CFG_WIDTH-1:0] i_divisor,
    output logic                 o_done,
    output logic [CFG_WIDTH-1:0] o_rem
);

    localparam int unsigned CNT_W = $clog2(KEY_WIDTH + 1);

    logic [KEY_WIDTH-1:0] r_num;
    logic [CFG_WIDTH-1:0] r_rem;
    logic [CFG_WIDTH-1:0] r_div;
    logic [CNT_W-1:0]     r_cnt;
    logic [CFG_WIDTH:0]   trial;
    logic [CFG_WIDTH-1:0] n_rem;

    // One quotient bit per cycle; the partial remainder stays below the divisor.
    always_comb begin
        trial = {r_rem, r_num[KEY_WIDTH-1]};
        if (trial >= {1'b0, r_div}) begin
            n_rem = CFG_WIDTH'(trial - {1'b0, r_div});
        end else begin
            n_rem = trial[CFG_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rem <= '0;
            r_div <= CFG_WIDTH'(1);
        end else if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
            r_cnt <= CNT_W'(KEY_WIDTH);
        end else if (r_cnt != '0) begin
            r_num <= {r_num[KEY_WIDTH-2:0], 1'b0};
            r_rem <= n_rem;
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    assign o_done = (r_cnt == '0);
    assign o_rem  = r_rem;

    `LLP_ASSERT(a_rem_below_div, i_clk, i_rst_n, o_done |-> (r_rem < r_div), "remainder not below divisor")

endmodule

/* rtl/llp_datapath.sv */
// ----------------------------------------------------------------------------
// llp_datapath
// Load counter memory, scan and compare logic, request and result registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module llp_datapath import llp_pkg::*; #(
    parameter int unsigned NUM_RANKS  = 1024,
    parameter int unsigned LOAD_WIDTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    output t_status                   o_status,
    input  logic                      i_cfg_we,
    input  logic [CFG_WIDTH-1:0]      i_cfg_data,
    input  logic [OPCODE_WIDTH-1:0]   i_opcode,
    input  logic [KEY_WIDTH-1:0]      i_affinity_key,
    input  logic [URG_WIDTH-1:0]      i_urgency,
    input  logic [TGT_WIDTH-1:0]      i_target_rank,
    output logic [RANK_OUT_WIDTH-1:0] o_chosen_rank,
    output logic [LOAD_OUT_WIDTH-1:0] o_load_value,
    output logic                      o_affinity_hit
);

    localparam int unsigned AW = $clog2(NUM_RANKS);
    localparam logic [LOAD_WIDTH-1:0] LOAD_MAX = {LOAD_WIDTH{1'b1}};

    // Captured request.
    logic [OPCODE_WIDTH-1:0] r_op;
    logic [KEY_WIDTH-1:0]    r_key;
    logic [URG_WIDTH-1:0]    r_urg;
    logic [TGT_WIDTH-1:0]    r_tgt;

    // Configuration and round-robin pointer.
    logic [CFG_WIDTH-1:0] r_active;
    logic [CFG_WIDTH-1:0] r_scan_start;
    logic [CFG_WIDTH-1:0] ws;
    logic [CFG_WIDTH-1:0] start_nxt;

    // Scan state.
    logic [CFG_WIDTH-1:0]  r_scan_rank;
    logic [CFG_WIDTH-1:0]  rank_nxt;
    logic [CFG_WIDTH-1:0]  r_left;
    logic                  r_rd_pend;
    logic [CFG_WIDTH-1:0]  r_data_rank;
    logic                  r_first;
    logic [CFG_WIDTH-1:0]  r_best_rank;
    logic [LOAD_WIDTH-1:0] r_min_load;

    logic [AW-1:0] r_clr_addr;

    // Result and output registers.
    logic [RANK_OUT_WIDTH-1:0] r_res_rank;
    logic [LOAD_OUT_WIDTH-1:0] r_res_load;
    logic                      r_res_hit;
    logic [RANK_OUT_WIDTH-1:0] r_out_rank;
    logic [LOAD_OUT_WIDTH-1:0] r_out_load;
    logic                      r_out_hit;

    // Memory ports.
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [LOAD_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [LOAD_WIDTH-1:0] ram_rdata;

    // Remainder unit.
    logic                 div_done;
    logic [CFG_WIDTH-1:0] div_rem;

    logic                  tgt_ok;
    logic                  upd_write;
    logic [LOAD_WIDTH-1:0] upd_value;
    logic                  hint;
    logic [1:0]            urg_cap;
    logic [2:0]            margin;
    logic [LOAD_WIDTH:0]   limit;
    logic                  home_ok;

    assign ws = (32'(r_active) > NUM_RANKS) ? CFG_WIDTH'(NUM_RANKS) : r_active;
    assign start_nxt = (r_scan_start + CFG_WIDTH'(1) == ws) ? '0
                                                            : r_scan_start + CFG_WIDTH'(1);
    assign rank_nxt = (r_scan_rank + CFG_WIDTH'(1) == ws) ? '0
                                                          : r_scan_rank + CFG_WIDTH'(1);
    assign tgt_ok = (32'(r_tgt) < NUM_RANKS);

    assign hint    = (r_key != '1);
    assign urg_cap = (r_urg > URG_WIDTH'(MARGIN_CAP)) ? 2'(MARGIN_CAP) : r_urg[1:0];
    assign margin  = 3'd1 + {1'b0, urg_cap};
    assign limit   = {1'b0, r_min_load} + (LOAD_WIDTH + 1)'(margin);
    assign home_ok = hint && ({1'b0, ram_rdata} <= limit);

    llp_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.scan_init),
        .i_dividend (r_key),
        .i_divisor  (ws),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    llp_ram #(
        .WIDTH (LOAD_WIDTH),
        .DEPTH (NUM_RANKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        priority if (i_cmd.scan_step) begin
            ram_raddr = AW'(r_scan_rank);
        end else if (i_cmd.home_rd) begin
            ram_raddr = AW'(div_rem);
        end else if (i_cmd.dispatch_rd && r_op == OP_CHOOSE) begin
            ram_raddr = '0;
        end else begin
            ram_raddr = AW'(r_tgt);
        end
    end

    // Saturating increment and floored decrement of the target counter.
    always_comb begin
        upd_write = 1'b0;
        upd_value = ram_rdata;
        if (r_op == OP_PLACE) begin
            upd_write = tgt_ok && (ram_rdata != LOAD_MAX);
            upd_value = ram_rdata + LOAD_WIDTH'(1);
        end else if (r_op == OP_DONE) begin
            upd_write = tgt_ok && (ram_rdata != '0);
            upd_value = ram_rdata - LOAD_WIDTH'(1);
        end
    end

    assign ram_we    = i_cmd.clr_step || (i_cmd.tgt_finish && upd_write);
    assign ram_waddr = i_cmd.clr_step ? r_clr_addr : AW'(r_tgt);
    assign ram_wdata = i_cmd.clr_step ? '0 : upd_value;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_opcode;
            r_key <= i_affinity_key;
            r_urg <= i_urgency;
            r_tgt <= i_target_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= ACTIVE_RESET;
            r_scan_start <= '0;
            r_clr_addr   <= '0;
            r_rd_pend    <= 1'b0;
            r_left       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_active     <= i_cfg_data;
                r_scan_start <= '0;
            end else if (i_cmd.scan_init) begin
                r_scan_start <= start_nxt;
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.scan_init) begin
                r_left    <= ws;
                r_rd_pend <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_rd_pend <= (r_left != '0);
                if (r_left != '0) begin
                    r_left <= r_left - CFG_WIDTH'(1);
                end
            end
        end
    end

    // Scan: keep the first strictly smaller load met in scan order.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_scan_rank <= r_scan_start;
            r_first     <= 1'b1;
        end else if (i_cmd.scan_step) begin
            if (r_left != '0) begin
                r_scan_rank <= rank_nxt;
                r_data_rank <= r_scan_rank;
            end
            if (r_rd_pend) begin
                r_first <= 1'b0;
                if (r_first || ram_rdata < r_min_load) begin
                    r_min_load  <= ram_rdata;
                    r_best_rank <= r_data_rank;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            if (home_ok) begin
                r_res_rank <= RANK_OUT_WIDTH'(div_rem);
                r_res_load <= LOAD_OUT_WIDTH'(ram_rdata);
                r_res_hit  <= 1'b1;
            end else begin
                r_res_rank <= RANK_OUT_WIDTH'(r_best_rank);
                r_res_load <= LOAD_OUT_WIDTH'(r_min_load);
                r_res_hit  <= 1'b0;
            end
        end else if (i_cmd.tgt_finish) begin
            r_res_rank <= '0;
            r_res_hit  <= 1'b0;
            unique case (r_op)
                OP_CHOOSE: r_res_load <= LOAD_OUT_WIDTH'(ram_rdata);
                OP_PLACE:  r_res_load <= '0;
                OP_DONE:   r_res_load <= '0;
                OP_READ:   r_res_load <= tgt_ok ? LOAD_OUT_WIDTH'(ram_rdata) : '0;
            endcase
        end
        if (i_cmd.out_load) begin
            r_out_rank <= r_res_rank;
            r_out_load <= r_res_load;
            r_out_hit  <= r_res_hit;
        end
    end

    assign o_status.clr_last  = (r_clr_addr == AW'(NUM_RANKS - 1));
    assign o_status.is_choose = (r_op == OP_CHOOSE);
    assign o_status.ws_zero   = (ws == '0);
    assign o_status.scan_done = (r_left == '0) && !r_rd_pend;
    assign o_status.div_done  = div_done;

    assign o_chosen_rank  = r_out_rank;
    assign o_load_value   = r_out_load;
    assign o_affinity_hit = r_out_hit;

    `LLP_ASSERT(a_ptr_in_range, i_clk, i_rst_n, (ws != '0) |-> (r_scan_start < ws), "scan pointer beyond rank count")

endmodule

/* rtl/llp_ctrl.sv */
// ----------------------------------------------------------------------------
// llp_ctrl
// Request sequencer: clearing pass, dispatch, scan, decision and delivery.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module llp_ctrl import llp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_cmd    o_cmd,
    input  t_status i_status
);

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_DISPATCH = 3'd2;
    localparam logic [2:0] S_SCAN     = 3'd3;
    localparam logic [2:0] S_HOME     = 3'd4;
    localparam logic [2:0] S_DECIDE   = 3'd5;
    localparam logic [2:0] S_FINISH   = 3'd6;
    localparam logic [2:0] S_OUT      = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_status.is_choose && !i_status.ws_zero) begin
                    o_cmd.scan_init = 1'b1;
                    n_state = S_SCAN;
                end else begin
                    o_cmd.dispatch_rd = 1'b1;
                    n_state = S_FINISH;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_done && i_status.div_done) begin
                    n_state = S_HOME;
                end
            end
            S_HOME: begin
                o_cmd.home_rd = 1'b1;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state = S_OUT;
            end
            S_FINISH: begin
                o_cmd.tgt_finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    `LLP_ASSERT(a_valid_from_out, i_clk, i_rst_n, $rose(r_out_valid) |-> ($past(r_state) == S_OUT), "result raised outside delivery")
    `LLP_ASSERT(a_no_accept_in_clear, i_clk, i_rst_n, (r_state == S_CLEAR) |-> !o_in_ready, "request taken during clearing pass")

endmodule

/* rtl/locality_aware_least_loaded_placer_top.sv */
// ----------------------------------------------------------------------------
// locality_aware_least_loaded_placer_top
// Least-loaded rank placer with a locality hint and per-rank load counters.
// ----------------------------------------------------------------------------
// After reset the block clears the load counter memory and accepts no
// request in that time; configuration writes are taken throughout. A
// choose request (opcode 0) scans the first W counters, where W is
// active_ranks capped at NUM_RANKS, reading one counter per cycle from the
// single read port of the counter memory, while a bit-serial unit computes
// the 64-bit key modulo W. It then reads the home counter, decides and
// loads the output register. Place, complete and read requests, and a
// choose with W of zero, go from dispatch straight to the counter update
// or read and then to the output register. Only one request is in work at
// a time, but a finished result waits in the output register, so the
// next request can be accepted before the previous result has been taken.
`include "assert_macros.svh"

module locality_aware_least_loaded_placer_top import llp_pkg::*; #(
    parameter int unsigned NUM_RANKS  = 1024,
    parameter int unsigned LOAD_WIDTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Request channel.
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [OPCODE_WIDTH-1:0]   i_opcode,
    input  logic [KEY_WIDTH-1:0]      i_affinity_key,
    input  logic [URG_WIDTH-1:0]      i_urgency,
    input  logic [TGT_WIDTH-1:0]      i_target_rank,
    // Result channel.
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [RANK_OUT_WIDTH-1:0] o_chosen_rank,
    output logic [LOAD_OUT_WIDTH-1:0] o_load_value,
    output logic                      o_affinity_hit,
    // Configuration: active rank count.
    input  logic                      i_cfg_we,
    input  logic [CFG_WIDTH-1:0]      i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    // The controller sequences each request; the datapath owns all storage.
    llp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    llp_datapath #(
        .NUM_RANKS  (NUM_RANKS),
        .LOAD_WIDTH (LOAD_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_opcode       (i_opcode),
        .i_affinity_key (i_affinity_key),
        .i_urgency      (i_urgency),
        .i_target_rank  (i_target_rank),
        .o_chosen_rank  (o_chosen_rank),
        .o_load_value   (o_load_value),
        .o_affinity_hit (o_affinity_hit)
    );

    // A request is only taken while no other request is in work.
    `LLP_ASSERT(a_one_in_work, i_clk, i_rst_n, (i_valid && o_ready) |=> !o_ready, "second request taken while busy")

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Placer testbench
// Drives choose, place, complete and read requests into the least-loaded
// placer, and predicts each result from its own copy of the per-rank load
// counters, the scan pointer and the active rank count. Every result is
// compared field by field, in order. Both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
    import llp_pkg::*;

    localparam int unsigned RANK_COUNT = 1024;
    localparam int unsigned LOAD_CEIL  = 16'hFFFF;
    localparam logic [KEY_WIDTH-1:0] NO_HINT_KEY = '1;
    localparam int unsigned TAIL_CYCLES = 100;
    localparam int unsigned RUN_PLACES  = 6;

    // One result as the block reports it.
    typedef struct packed {
        logic [RANK_OUT_WIDTH-1:0] rank;
        logic [LOAD_OUT_WIDTH-1:0] load;
        logic                      hit;
    } t_placement;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_ready;
    logic [OPCODE_WIDTH-1:0]   i_opcode = OP_READ;
    logic [KEY_WIDTH-1:0]      i_affinity_key = '0;
    logic [URG_WIDTH-1:0]      i_urgency = '0;
    logic [TGT_WIDTH-1:0]      i_target_rank = '0;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic [RANK_OUT_WIDTH-1:0] o_chosen_rank;
    logic [LOAD_OUT_WIDTH-1:0] o_load_value;
    logic                      o_affinity_hit;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_WIDTH-1:0]      i_cfg_data = '0;

    // Shadow copy of the block's state, advanced as each request is accepted.
    logic [LOAD_OUT_WIDTH-1:0] load_tbl [RANK_COUNT];
    logic [RANK_OUT_WIDTH-1:0] scan_ptr;
    logic [CFG_WIDTH-1:0]      active_cfg;

    // Results still owed by the block, oldest first.
    t_placement pending_q[$];
    int         err_count = 0;
    bit         idle_on = 1'b0;
    // Length of a long receiver stall; the result side picks it up and counts.
    int         hold_request = 0;

    always #2 i_clk = ~i_clk;

    locality_aware_least_loaded_placer_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_opcode       (i_opcode),
        .i_affinity_key (i_affinity_key),
        .i_urgency      (i_urgency),
        .i_target_rank  (i_target_rank),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_chosen_rank  (o_chosen_rank),
        .o_load_value   (o_load_value),
        .o_affinity_hit (o_affinity_hit),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    // Works out the result of one request and applies its effect to the
    // shadow counters and pointer.
    function automatic t_placement predict_placement(
        input logic [OPCODE_WIDTH-1:0] op,
        input logic [KEY_WIDTH-1:0]    key,
        input logic [URG_WIDTH-1:0]    urg,
        input logic [TGT_WIDTH-1:0]    tgt
    );
        t_placement  res;
        int unsigned ws, start, best, min_load, r, s, home, margin;
        res = '0;
        case (op)
            OP_CHOOSE: begin
                ws = active_cfg;
                if (ws == 0) begin
                    // No ranks taking part: rank 0 is reported, pointer stays.
                    res.load = load_tbl[0];
                end else begin
                    if (ws > RANK_COUNT) begin
                        ws = RANK_COUNT;
                    end
                    start    = scan_ptr % ws;
                    best     = start;
                    min_load = load_tbl[start];
                    r        = start;
                    for (s = 1; s < ws; s++) begin
                        r = (r + 1 == ws) ? 0 : r + 1;
                        // Strictly less: ties stay with the first rank met.
                        if (load_tbl[r] < min_load) begin
                            min_load = load_tbl[r];
                            best     = r;
                        end
                    end
                    scan_ptr = RANK_OUT_WIDTH'((start + 1 == ws) ? 0 : start + 1);
                    res.rank = RANK_OUT_WIDTH'(best);
                    res.load = LOAD_OUT_WIDTH'(min_load);
                    if (key != NO_HINT_KEY) begin
                        home   = 32'(key % 64'(ws));
                        margin = 1 + ((urg > MARGIN_CAP) ? MARGIN_CAP : urg);
                        if (load_tbl[home] <= min_load + margin) begin
                            res.rank = RANK_OUT_WIDTH'(home);
                            res.load = load_tbl[home];
                            res.hit  = 1'b1;
                        end
                    end
                end
            end
            OP_PLACE: begin
                if (load_tbl[tgt] != LOAD_CEIL) begin
                    load_tbl[tgt] = load_tbl[tgt] + 1'b1;
                end
            end
            OP_DONE: begin
                if (load_tbl[tgt] != 0) begin
                    load_tbl[tgt] = load_tbl[tgt] - 1'b1;
                end
            end
            default: begin
                res.load = load_tbl[tgt];
            end
        endcase
        return res;
    endfunction

    function automatic logic [KEY_WIDTH-1:0] random_key();
        return {$urandom(), $urandom()};
    endfunction

    task automatic report_mismatch(input string what);
        err_count++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // Offers one request and returns at the edge where it is accepted, with
    // valid still high so that the next request can follow at once.
    task automatic send_request(
        input logic [OPCODE_WIDTH-1:0] op,
        input logic [KEY_WIDTH-1:0]    key,
        input logic [URG_WIDTH-1:0]    urg,
        input logic [TGT_WIDTH-1:0]    tgt
    );
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_opcode       <= op;
        i_affinity_key <= key;
        i_urgency      <= urg;
        i_target_rank  <= tgt;
        do @(posedge i_clk); while (!o_ready);
        pending_q.push_back(predict_placement(op, key, urg, tgt));
    endtask

    // Stops offering and waits until every owed result has come back.
    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    // Writes the active rank count; only called while the block is idle.
    task automatic write_active(input logic [CFG_WIDTH-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        active_cfg = value;
        scan_ptr   = '0;
        @(posedge i_clk);
    endtask

    // Runs with the count left at its reset value of one rank.
    task automatic test_reset_defaults();
        send_request(OP_CHOOSE, NO_HINT_KEY, '0, '0);
        send_request(OP_READ, random_key(), 4'hF, 10'h3FF);
        send_request(OP_PLACE, '0, '0, 10'h3FF);
        send_request(OP_READ, '0, '0, 10'h3FF);
        // A completion on an empty counter must leave it at zero.
        send_request(OP_DONE, '0, '0, '0);
        send_request(OP_CHOOSE, 64'd12345, '0, '0);
        wait_for_results();
    endtask

    // Four ranks loaded as 2, 0, 0, 4: ties, pointer rotation and the
    // locality margin at each urgency step.
    task automatic test_choose_rules();
        write_active(CFG_WIDTH'(4));
        repeat (2) send_request(OP_PLACE, '0, '0, 10'd0);
        repeat (4) send_request(OP_PLACE, '0, '0, 10'd3);
        send_request(OP_CHOOSE, NO_HINT_KEY, 4'd3, '0);
        send_request(OP_CHOOSE, NO_HINT_KEY, '0, '0);
        send_request(OP_CHOOSE, 64'd3, 4'd0, '0);
        send_request(OP_CHOOSE, 64'd3, 4'd3, '0);
        send_request(OP_CHOOSE, 64'd3, 4'd15, '0);
        send_request(OP_CHOOSE, NO_HINT_KEY - 1, 4'd2, '0);
        wait_for_results();
    endtask

    task automatic test_zero_ranks();
        write_active('0);
        send_request(OP_CHOOSE, random_key(), 4'hF, 10'h3FF);
        send_request(OP_PLACE, '0, '0, 10'd0);
        send_request(OP_CHOOSE, NO_HINT_KEY, '0, '0);
        wait_for_results();
    endtask

    // Full-length scans: a count above the rank total saturates.
    task automatic test_wide_scan();
        write_active('1);
        send_request(OP_CHOOSE, NO_HINT_KEY, '0, '0);
        send_request(OP_CHOOSE, random_key(), 4'($urandom_range(0, 15)), '0);
        wait_for_results();
        write_active(CFG_WIDTH'(RANK_COUNT));
        send_request(OP_CHOOSE, random_key(), 4'($urandom_range(0, 15)), '0);
        send_request(OP_READ, '0, '0, 10'h3FF);
        wait_for_results();
    endtask

    // The result side holds off long enough that the block fills and stops
    // taking requests; afterwards the sender waits for everything to drain.
    task automatic test_backpressure();
        int idx;
        write_active(CFG_WIDTH'(2));
        hold_request = 400;
        for (idx = 0; idx < 12; idx++) begin
            send_request(2'($urandom_range(0, 3)), random_key(),
                         4'($urandom_range(0, 15)), 10'($urandom_range(0, 3)));
        end
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        int          phase, idx, count, pick;
        int unsigned ranks, span;
        logic [OPCODE_WIDTH-1:0] op;
        logic [KEY_WIDTH-1:0]    key;
        logic [TGT_WIDTH-1:0]    tgt;
        for (phase = 0; phase < 22; phase++) begin
            // Every fourth phase runs without any idling.
            idle_on = (phase % 4 != 3);
            count   = 25;
            case ($urandom_range(0, 9))
                0: ranks = 1;
                1: ranks = 2;
                7: ranks = $urandom_range(17, 64);
                8: begin
                    // Long scans are slow, so these phases stay short.
                    ranks = $urandom_range(65, 2047);
                    count = 6;
                end
                9: ranks = $urandom_range(0, 1) ? 0 : 5;
                default: ranks = $urandom_range(3, 16);
            endcase
            write_active(CFG_WIDTH'(ranks));
            span = (ranks + 1 > RANK_COUNT - 1) ? RANK_COUNT - 1 : ranks + 1;
            for (idx = 0; idx < count; idx++) begin
                pick = $urandom_range(0, 99);
                if (pick < 35) begin
                    op = OP_CHOOSE;
                end else if (pick < 70) begin
                    op = OP_PLACE;
                end else if (pick < 85) begin
                    op = OP_DONE;
                end else begin
                    op = OP_READ;
                end
                // Keep most counter traffic on the active ranks so that
                // loads differ by a little and the margin decides.
                if ($urandom_range(0, 4) != 0) begin
                    tgt = 10'($urandom_range(0, span));
                end else begin
                    tgt = 10'($urandom_range(0, RANK_COUNT - 1));
                end
                case ($urandom_range(0, 7))
                    0: key = NO_HINT_KEY;
                    1, 2: key = 64'($urandom_range(0, 4 * ranks + 3));
                    default: key = random_key();
                endcase
                send_request(op, key, 4'($urandom_range(0, 15)), tgt);
            end
            wait_for_results();
        end
    endtask

    // Runs one counter up by a handful of placements, then down and up again,
    // back to back with no idling.
    task automatic test_counter_run();
        int idx;
        idle_on = 1'b0;
        write_active(CFG_WIDTH'(2));
        for (idx = 0; idx < RUN_PLACES; idx++) begin
            send_request(OP_PLACE, random_key(), 4'($urandom_range(0, 15)), 10'd1);
        end
        send_request(OP_READ, '0, '0, 10'd1);
        send_request(OP_CHOOSE, 64'd1, 4'd15, '0);
        send_request(OP_DONE, '0, '0, 10'd1);
        send_request(OP_READ, '0, '0, 10'd1);
        repeat (2) send_request(OP_PLACE, '0, '0, 10'd1);
        send_request(OP_READ, '0, '0, 10'd1);
        wait_for_results();
    endtask

    // Result side: checks each accepted result against the oldest prediction
    // and decides the ready level for the next edge.
    initial begin : result_side
        int         gap_left;
        int         hold_left;
        t_placement want;
        gap_left  = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (pending_q.size() == 0) begin
                    report_mismatch($sformatf("result rank %0d load %0d with none owed",
                                              o_chosen_rank, o_load_value));
                end else begin
                    want = pending_q.pop_front();
                    if (o_chosen_rank !== want.rank) begin
                        report_mismatch($sformatf("chosen_rank %0d, expected %0d",
                                                  o_chosen_rank, want.rank));
                    end
                    if (o_load_value !== want.load) begin
                        report_mismatch($sformatf("load_value %0d, expected %0d",
                                                  o_load_value, want.load));
                    end
                    if (o_affinity_hit !== want.hit) begin
                        report_mismatch($sformatf("affinity_hit %0b, expected %0b",
                                                  o_affinity_hit, want.hit));
                    end
                end
            end
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                i_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                gap_left = $urandom_range(0, 2);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Main sequence. The block clears its counters after reset; the first
    // request simply waits for ready.
    initial begin
        int idx;
        for (idx = 0; idx < RANK_COUNT; idx++) begin
            load_tbl[idx] = '0;
        end
        scan_ptr   = '0;
        active_cfg = ACTIVE_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_on = 1'b1;
        test_reset_defaults();
        test_choose_rules();
        test_zero_ranks();
        test_wide_scan();
        test_backpressure();
        test_random_traffic();
        test_counter_run();
        // Quiet tail to catch any stray result.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_q.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_q.size()));
        end
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog: several times the slowest correct run, which is the one where
    // every random phase draws full-length scans.
    initial begin
        #3000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/llp_pkg.sv
rtl/llp_ram.sv
rtl/llp_mod.sv
rtl/llp_datapath.sv
rtl/llp_ctrl.sv
rtl/locality_aware_least_loaded_placer_top.sv
dv/testbench.sv
